// ===== rtl/mtf_pkg.sv =====
// shared types and constants of the move-to-front recency list
package mtf_pkg;

  localparam int MAX_APPS_DEFAULT = 16;
  localparam int ID_W             = 32;
  localparam int CNT_W            = 8;
  localparam int COUNT_W          = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_USE    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_AT_FRONT  = 3'd3,
    ST_BAD_COUNT = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_LIST
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MATCH,
    CELL_PUSH,
    CELL_MOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic found;
    logic at_front;
  } chain_stat_t;

endpackage

// ===== rtl/mtf_if.sv =====
// request and result channel interfaces
interface mtf_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [mtf_pkg::ID_W-1:0]     app_id;
  logic [mtf_pkg::CNT_W-1:0]    remove_count;

  modport source (output valid, opcode, app_id, remove_count, input ready);
  modport sink (input valid, opcode, app_id, remove_count, output ready);
  modport monitor (input valid, ready, opcode, app_id, remove_count);
endinterface

interface mtf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [mtf_pkg::ID_W-1:0]     entry_id;
  logic [mtf_pkg::COUNT_W-1:0]  entry_count;
  logic                         last_of_run;

  modport source (output valid, status, entry_id, entry_count, last_of_run, input ready);
  modport sink (input valid, status, entry_id, entry_count, last_of_run, output ready);
  modport monitor (input valid, ready, status, entry_id, entry_count, last_of_run);
endinterface

// ===== rtl/mtf_cell.sv =====
// one slot of the recency chain with its match flag
module mtf_cell #(
  parameter int MAX_APPS = mtf_pkg::MAX_APPS_DEFAULT,
  parameter int IDX      = 0
) (
  input  logic                       clk,
  input  mtf_pkg::cell_op_t          cell_op,
  input  logic [$clog2(MAX_APPS+1)-1:0] occ,
  input  logic [mtf_pkg::ID_W-1:0]   key,
  input  logic [mtf_pkg::ID_W-1:0]   left,
  input  logic [mtf_pkg::ID_W-1:0]   right,
  input  logic [mtf_pkg::ID_W-1:0]   wrap,
  input  logic                       hit_in,
  output logic                       hit_out,
  output logic [mtf_pkg::ID_W-1:0]   slot
);

  localparam int OCC_W = $clog2(MAX_APPS + 1);

  logic match_q;
  logic in_use;
  logic is_tail;

  assign in_use  = occ > OCC_W'(IDX);
  assign is_tail = occ == OCC_W'(IDX + 1);
  assign hit_out = hit_in | match_q;

  always_ff @(posedge clk) begin
    case (cell_op)
      mtf_pkg::CELL_MATCH: match_q <= in_use && (slot == key);
      mtf_pkg::CELL_PUSH: slot <= left;
      mtf_pkg::CELL_MOVE: begin
        if (!hit_in) begin
          slot <= left;
        end
      end
      mtf_pkg::CELL_ROTATE: slot <= is_tail ? wrap : right;
      default: ;
    endcase
  end

endmodule

// ===== rtl/mtf_ctrl.sv =====
// command sequencer, occupancy count and result register
module mtf_ctrl #(
  parameter int MAX_APPS = mtf_pkg::MAX_APPS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  mtf_cmd_if.sink                       cmd,
  mtf_rsp_if.source                     rsp,
  input  mtf_pkg::chain_stat_t          stat,
  input  logic [mtf_pkg::ID_W-1:0]      front_id,
  output mtf_pkg::cell_op_t             cell_op,
  output logic [$clog2(MAX_APPS+1)-1:0] occ,
  output logic [mtf_pkg::ID_W-1:0]      cmd_id
);

  localparam int OCC_W = $clog2(MAX_APPS + 1);

  mtf_pkg::state_t  state, state_next;
  mtf_pkg::op_t     cmd_op;
  logic [mtf_pkg::CNT_W-1:0] cmd_cnt;
  logic [OCC_W-1:0] occ_next;
  logic [OCC_W-1:0] idx, idx_next;

  logic                         rsp_valid;
  mtf_pkg::status_t             rsp_status;
  logic [mtf_pkg::ID_W-1:0]     rsp_id;
  logic [mtf_pkg::COUNT_W-1:0]  rsp_count;
  logic                         rsp_last;

  logic                         fire;
  logic                         emit;
  logic                         list_last;
  mtf_pkg::status_t             emit_status;
  logic [mtf_pkg::ID_W-1:0]     emit_id;
  logic                         emit_last;

  assign cmd.ready = state == mtf_pkg::S_IDLE;
  assign fire      = !rsp_valid || rsp.ready;
  assign list_last = (idx + OCC_W'(1)) == occ;

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_id    = rsp_id;
  assign rsp.entry_count = rsp_count;
  assign rsp.last_of_run = rsp_last;

  always_comb begin
    state_next = state;
    case (state)
      mtf_pkg::S_IDLE: begin
        if (cmd.valid) begin
          state_next = (mtf_pkg::op_t'(cmd.opcode) == mtf_pkg::OP_USE) ?
                       mtf_pkg::S_CMP : mtf_pkg::S_EXEC;
        end
      end
      mtf_pkg::S_CMP: state_next = mtf_pkg::S_EXEC;
      mtf_pkg::S_EXEC: begin
        if (fire) begin
          state_next = (cmd_op == mtf_pkg::OP_LIST && occ != '0) ?
                       mtf_pkg::S_LIST : mtf_pkg::S_IDLE;
        end
      end
      mtf_pkg::S_LIST: begin
        if (fire && list_last) begin
          state_next = mtf_pkg::S_IDLE;
        end
      end
      default: state_next = mtf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cell_op     = mtf_pkg::CELL_HOLD;
    emit        = 1'b0;
    emit_status = mtf_pkg::ST_OK;
    emit_id     = '0;
    emit_last   = 1'b1;
    occ_next    = occ;
    idx_next    = idx;
    case (state)
      mtf_pkg::S_CMP: cell_op = mtf_pkg::CELL_MATCH;
      mtf_pkg::S_EXEC: begin
        if (fire) begin
          emit = 1'b1;
          case (cmd_op)
            mtf_pkg::OP_ADD: begin
              emit_id = cmd_id;
              if (occ == OCC_W'(MAX_APPS)) begin
                emit_status = mtf_pkg::ST_FULL;
              end else begin
                cell_op  = mtf_pkg::CELL_PUSH;
                occ_next = occ + OCC_W'(1);
              end
            end
            mtf_pkg::OP_USE: begin
              emit_id = cmd_id;
              if (occ == '0) begin
                emit_status = mtf_pkg::ST_EMPTY;
              end else if (!stat.found) begin
                emit_status = mtf_pkg::ST_NOT_FOUND;
              end else if (stat.at_front) begin
                emit_status = mtf_pkg::ST_AT_FRONT;
              end else begin
                cell_op = mtf_pkg::CELL_MOVE;
              end
            end
            mtf_pkg::OP_REMOVE: begin
              if (occ == '0) begin
                emit_status = mtf_pkg::ST_EMPTY;
              end else if (cmd_cnt == '0 || cmd_cnt > mtf_pkg::CNT_W'(occ)) begin
                emit_status = mtf_pkg::ST_BAD_COUNT;
              end else begin
                occ_next = occ - OCC_W'(cmd_cnt);
              end
            end
            mtf_pkg::OP_LIST: begin
              if (occ == '0) begin
                emit_status = mtf_pkg::ST_EMPTY;
              end else begin
                emit     = 1'b0;
                idx_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      mtf_pkg::S_LIST: begin
        if (fire) begin
          emit      = 1'b1;
          emit_id   = front_id;
          emit_last = list_last;
          cell_op   = mtf_pkg::CELL_ROTATE;
          idx_next  = idx + OCC_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtf_pkg::S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.valid && cmd.ready) begin
      cmd_op  <= mtf_pkg::op_t'(cmd.opcode);
      cmd_id  <= cmd.app_id;
      cmd_cnt <= cmd.remove_count;
    end
    if (emit) begin
      rsp_status <= emit_status;
      rsp_id     <= emit_id;
      rsp_count  <= mtf_pkg::COUNT_W'(occ_next);
      rsp_last   <= emit_last;
    end
  end

endmodule

// ===== rtl/move_to_front_recency_list.sv =====
// top level of the move-to-front recency list
//
// cmd carries one request: opcode (add, use, remove from tail, list), app_id
// and remove_count; rsp returns results with status, entry_id, entry_count
// and last_of_run. a request is taken when valid and ready are both high.
// add, remove and an empty list pass through acceptance and execution.
// use adds a compare step between them to register the compare of every
// cell against the id, after which the first hit ripples down the chain
// and the cells in front of it shift back by one.
// list adds a listing step after execution: the chain rotates one place
// a cycle while rsp is not stalled and the front cell is sent each time;
// one result goes out per entry and the rotation leaves the order as it was.
// results are registered in a single output register once they are formed;
// a new request is taken while that register still waits.
// when rsp is stalled execution and listing hold and the chain does not move.
// reset empties the list and clears the result valid flag; the slot contents
// are left as they are and only slots below the entry count are ever read.
module move_to_front_recency_list #(
  parameter int MAX_APPS = mtf_pkg::MAX_APPS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  mtf_cmd_if.sink   cmd,
  mtf_rsp_if.source rsp
);

  localparam int OCC_W = $clog2(MAX_APPS + 1);

  mtf_pkg::cell_op_t          cell_op;
  mtf_pkg::chain_stat_t       stat;
  logic [OCC_W-1:0]           occ;
  logic [mtf_pkg::ID_W-1:0]   cmd_id;
  logic [mtf_pkg::ID_W-1:0]   slots   [MAX_APPS];
  logic [mtf_pkg::ID_W-1:0]   left_d  [MAX_APPS];
  logic [mtf_pkg::ID_W-1:0]   right_d [MAX_APPS];
  logic [MAX_APPS:0]          hits;

  assign hits[0]       = 1'b0;
  assign stat.found    = hits[MAX_APPS];
  assign stat.at_front = hits[1];

  mtf_ctrl #(.MAX_APPS(MAX_APPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rsp      (rsp),
    .stat     (stat),
    .front_id (slots[0]),
    .cell_op  (cell_op),
    .occ      (occ),
    .cmd_id   (cmd_id)
  );

  for (genvar i = 0; i < MAX_APPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_d[i] = cmd_id;
    end else begin : g_body
      assign left_d[i] = slots[i-1];
    end
    if (i == MAX_APPS - 1) begin : g_tail
      assign right_d[i] = slots[0];
    end else begin : g_mid
      assign right_d[i] = slots[i+1];
    end

    mtf_cell #(.MAX_APPS(MAX_APPS), .IDX(i)) u_cell (
      .clk     (clk),
      .cell_op (cell_op),
      .occ     (occ),
      .key     (cmd_id),
      .left    (left_d[i]),
      .right   (right_d[i]),
      .wrap    (slots[0]),
      .hit_in  (hits[i]),
      .hit_out (hits[i+1]),
      .slot    (slots[i])
    );
  end

endmodule

// ===== rtl/mtf_checker.sv =====
// port-level checks of the recency list, bound to the top level
module mtf_checker #(
  parameter int MAX_APPS = mtf_pkg::MAX_APPS_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [2:0]                   rsp_status,
  input logic [mtf_pkg::ID_W-1:0]     rsp_entry_id,
  input logic [mtf_pkg::COUNT_W-1:0]  rsp_entry_count,
  input logic                         rsp_last_of_run
);

  ap_reset_idle: assert property (@(posedge clk)
    rst |=> cmd_ready && !rsp_valid)
    else $error("not idle after reset");

  ap_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == mtf_pkg::ST_FULL |->
      rsp_entry_count == mtf_pkg::COUNT_W'(MAX_APPS))
    else $error("full status with list not full");

  ap_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == mtf_pkg::ST_EMPTY |->
      rsp_entry_count == '0 && rsp_last_of_run)
    else $error("empty status with entries held");

  ap_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= mtf_pkg::COUNT_W'(MAX_APPS))
    else $error("entry count above capacity");

  ap_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_id) &&
      $stable(rsp_status) && $stable(rsp_last_of_run))
    else $error("stalled result changed");

endmodule

bind move_to_front_recency_list mtf_checker #(.MAX_APPS(MAX_APPS)) u_mtf_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_entry_id    (rsp.entry_id),
  .rsp_entry_count (rsp.entry_count),
  .rsp_last_of_run (rsp.last_of_run)
);
